// ===== rtl/core/brtc_pkg.sv =====
// ----------------------------------------------------------------------------
// brtc_pkg
// Shared constants, register indexes and tables of the tilt controller core.
// ----------------------------------------------------------------------------
package brtc_pkg;

    localparam int RATE_RATIO_DEF   = 140;
    localparam int GEAR_DIVISOR_DEF = 111;
    localparam int TICK_SCALE_DEF   = 10;
    localparam int SETTLE_TICKS_DEF = 5;

    localparam int RATE_DIVISOR = 29;
    localparam int DECAY_NUM    = 999;
    localparam int DECAY_DEN    = 1000;
    localparam int PERCENT      = 100;
    localparam int HALF_TURN    = 179999;
    localparam int CORDIC_STEPS = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_ZERO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_ANGLE    = 3'd7;

    // Arctangent of 2^-i in millidegrees.
    function automatic logic [15:0] atan_step(input logic [3:0] idx);
        logic [15:0] v;
        unique case (idx)
            4'd0:  v = 16'd45000;
            4'd1:  v = 16'd26565;
            4'd2:  v = 16'd14036;
            4'd3:  v = 16'd7125;
            4'd4:  v = 16'd3576;
            4'd5:  v = 16'd1790;
            4'd6:  v = 16'd895;
            4'd7:  v = 16'd448;
            4'd8:  v = 16'd224;
            4'd9:  v = 16'd112;
            4'd10: v = 16'd56;
            4'd11: v = 16'd28;
            4'd12: v = 16'd14;
            4'd13: v = 16'd7;
            4'd14: v = 16'd3;
            4'd15: v = 16'd2;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/brtc_in_if.sv =====
// ----------------------------------------------------------------------------
// brtc_in_if
// Sensor tick channel: gyro, accelerometer and wheel encoder samples.
// ----------------------------------------------------------------------------
interface brtc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] enc_left;
    logic signed [15:0] enc_right;

    modport source (output valid, gyro_rate, accel_x, accel_y, enc_left, enc_right,
                    input ready);
    modport sink   (input valid, gyro_rate, accel_x, accel_y, enc_left, enc_right,
                    output ready);
endinterface

// ===== rtl/core/brtc_out_if.sv =====
// ----------------------------------------------------------------------------
// brtc_out_if
// Motor command channel: both wheel drives, mode and tilt.
// ----------------------------------------------------------------------------
interface brtc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               balancing_now;
    logic signed [31:0] tilt_out;

    modport source (output valid, left_drive, right_drive, balancing_now, tilt_out,
                    input ready);
    modport sink   (input valid, left_drive, right_drive, balancing_now, tilt_out,
                    output ready);
endinterface

// ===== rtl/core/balance_robot_tilt_controller_core.sv =====
// ----------------------------------------------------------------------------
// balance_robot_tilt_controller_core
// Tilt estimator and balance controller, one command per sensor tick.
// ----------------------------------------------------------------------------
// One sensor tick is processed at a time on a single shared 34x14 multiplier,
// a reciprocal divider that produces three 16-bit quotient digits, and a
// 16-step CORDIC datapath. A tick takes four divisions while balancing and
// one while lying down; there the CORDIC re-levels the tilt when the gyro
// is quiet. A finished tick waits while the output register holds an
// untaken command. The input is ready only while the sequencer is idle. A
// finished command waits in an output register, so the next tick can be
// taken before the previous command is consumed.
module balance_robot_tilt_controller_core #(
    parameter int RATE_RATIO   = brtc_pkg::RATE_RATIO_DEF,
    parameter int GEAR_DIVISOR = brtc_pkg::GEAR_DIVISOR_DEF,
    parameter int TICK_SCALE   = brtc_pkg::TICK_SCALE_DEF,
    parameter int SETTLE_TICKS = brtc_pkg::SETTLE_TICKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    brtc_in_if.sink                          i_tick,
    brtc_out_if.source                       o_cmd,
    input  logic                             i_cfg_we,
    input  logic [brtc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [brtc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import brtc_pkg::*;

    localparam int GEAR_DIV   = PERCENT * GEAR_DIVISOR;
    localparam int DIV_DIGITS = 3;

    // Reciprocal of each divisor, exact for partial dividends below divisor * 2^16.
    localparam int RSH_RATE  = 16 + 2 * $clog2(RATE_DIVISOR);
    localparam int RSH_DECAY = 16 + 2 * $clog2(DECAY_DEN);
    localparam int RSH_GEAR  = 16 + 2 * $clog2(GEAR_DIV);
    localparam int RSH_PCT   = 16 + 2 * $clog2(PERCENT);
    localparam longint RCP_RATE  =
        ((longint'(1) << RSH_RATE) + RATE_DIVISOR - 1) / RATE_DIVISOR;
    localparam longint RCP_DECAY =
        ((longint'(1) << RSH_DECAY) + DECAY_DEN - 1) / DECAY_DEN;
    localparam longint RCP_GEAR  =
        ((longint'(1) << RSH_GEAR) + GEAR_DIV - 1) / GEAR_DIV;
    localparam longint RCP_PCT   =
        ((longint'(1) << RSH_PCT) + PERCENT - 1) / PERCENT;

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_DLD     = 19'h00002,
        S_DIV     = 19'h00004,
        S_RATE_Q  = 19'h00008,
        S_M_TICK  = 19'h00010,
        S_W_TILT  = 19'h00020,
        S_M_DECAY = 19'h00040,
        S_DECAY_Q = 19'h00080,
        S_M_RISE  = 19'h00100,
        S_A_RISE  = 19'h00200,
        S_M_ANG   = 19'h00400,
        S_M_DIST  = 19'h00800,
        S_M_SPD   = 19'h01000,
        S_A_SPD   = 19'h02000,
        S_INC_Q   = 19'h04000,
        S_M_STEER = 19'h08000,
        S_STEER_Q = 19'h10000,
        S_CORDIC  = 19'h20000,
        S_FINISH  = 19'h40000
    } t_state;

    t_state r_state, r_ret;

    // Configuration.
    logic signed [15:0] r_gyro_zero;
    logic [9:0]         r_angle_gain, r_distance_gain, r_speed_limit;
    logic [12:0]        r_speed_gain;
    logic signed [10:0] r_steer_gain;
    logic [17:0]        r_start_angle, r_stop_angle;

    // Controller state.
    logic signed [31:0] r_tilt, r_motor, r_dist_l, r_dist_r;
    logic [15:0]        r_prev_l, r_prev_r;
    logic [2:0]         r_settle;
    logic               r_mode;

    // Per-tick working registers.
    logic signed [15:0] r_ax, r_ay, r_enc_l, r_enc_r;
    logic signed [12:0] r_rate;
    logic signed [15:0] r_dl, r_dr;
    logic signed [33:0] r_rising;
    logic signed [47:0] r_prod, r_acc;
    logic signed [15:0] r_left, r_right;

    // Divider.
    logic [47:0]        r_quo;
    logic [14:0]        r_rem;
    logic [15:0]        r_qd;
    logic               r_neg;
    logic [2:0]         r_dcnt;

    // CORDIC.
    logic signed [19:0] r_cx, r_cy;
    logic signed [20:0] r_cz;
    logic [3:0]         r_ccnt;

    // Output register.
    logic               r_ov;
    logic signed [15:0] r_o_left, r_o_right;
    logic               r_o_bal;
    logic signed [31:0] r_o_tilt;

    // Shared multiplier operand selection.
    logic signed [33:0] w_ma;
    logic signed [13:0] w_mb;
    logic signed [47:0] w_mul;

    always_comb begin
        w_ma = 34'(r_rate);
        w_mb = 14'(TICK_SCALE);
        unique case (r_state)
            S_M_TICK:  begin w_ma = 34'(r_rate);  w_mb = 14'(TICK_SCALE); end
            S_M_DECAY: begin w_ma = 34'(r_tilt);  w_mb = 14'(DECAY_NUM); end
            S_M_RISE:  begin w_ma = 34'(r_rate);  w_mb = 14'(RATE_RATIO); end
            S_M_ANG:   begin
                w_ma = r_rising;
                w_mb = $signed({4'b0, r_angle_gain});
            end
            S_M_DIST:  begin
                w_ma = 34'(r_dist_l) + 34'(r_dist_r);
                w_mb = $signed({4'b0, r_distance_gain});
            end
            S_M_SPD:   begin
                w_ma = 34'(r_dl) + 34'(r_dr);
                w_mb = $signed({1'b0, r_speed_gain});
            end
            S_M_STEER: begin
                w_ma = 34'(r_dist_l) - 34'(r_dist_r);
                w_mb = 14'(r_steer_gain);
            end
            default: ;
        endcase
    end

    assign w_mul = 48'(w_ma * w_mb);

    // Divider digit step and signed quotient.
    logic signed [47:0] w_dsrc;
    logic [47:0]        w_dmag;
    logic [14:0]        w_dsr;
    logic [31:0]        w_rcp;
    logic [30:0]        w_t;
    logic [63:0]        w_rprod;
    logic [15:0]        w_digit;
    logic [30:0]        w_qd;
    logic signed [47:0] w_q;

    assign w_dsrc  = (r_ret == S_INC_Q) ? r_acc : r_prod;
    assign w_dmag  = w_dsrc[47] ? 48'(-w_dsrc) : 48'(w_dsrc);

    always_comb begin
        w_dsr = 15'(RATE_DIVISOR);
        w_rcp = 32'(RCP_RATE);
        unique case (r_ret)
            S_DECAY_Q: begin w_dsr = 15'(DECAY_DEN); w_rcp = 32'(RCP_DECAY); end
            S_INC_Q:   begin w_dsr = 15'(GEAR_DIV);  w_rcp = 32'(RCP_GEAR);  end
            S_STEER_Q: begin w_dsr = 15'(PERCENT);   w_rcp = 32'(RCP_PCT);   end
            default: ;
        endcase
    end

    // Partial dividend: remainder so far followed by the next 16 dividend bits.
    assign w_t     = {r_rem, r_quo[47:32]};
    assign w_rprod = 64'(w_t) * 64'(w_rcp);
    assign w_qd    = 31'(r_qd) * 31'(w_dsr);

    always_comb begin
        w_digit = 16'(w_rprod >> RSH_RATE);
        unique case (r_ret)
            S_DECAY_Q: w_digit = 16'(w_rprod >> RSH_DECAY);
            S_INC_Q:   w_digit = 16'(w_rprod >> RSH_GEAR);
            S_STEER_Q: w_digit = 16'(w_rprod >> RSH_PCT);
            default: ;
        endcase
    end

    assign w_q     = r_neg ? -$signed(r_quo) : $signed(r_quo);

    // Increment clamp.
    logic signed [47:0] w_lim, w_inc;
    assign w_lim = $signed({38'b0, r_speed_limit});
    always_comb begin
        priority if (w_q > w_lim) w_inc = w_lim;
        else if (w_q < -w_lim)    w_inc = -w_lim;
        else                      w_inc = w_q;
    end

    // Steering and drive saturation.
    logic signed [40:0] w_lsum, w_rsum;
    assign w_lsum = 41'(r_motor) + 41'($signed(w_q[39:0]));
    assign w_rsum = 41'(r_motor) - 41'($signed(w_q[39:0]));

    function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
        logic signed [15:0] r;
        priority if (v > 41'sd32767) r = 16'sh7fff;
        else if (v < -41'sd32768)    r = 16'sh8000;
        else                         r = v[15:0];
        return r;
    endfunction

    // Encoder deltas of the latched tick.
    logic signed [15:0] w_dl, w_dr;
    assign w_dl = r_enc_l - r_prev_l;
    assign w_dr = r_enc_r - r_prev_r;

    // CORDIC micro-rotation.
    logic signed [19:0] w_xs, w_ys, w_cx, w_cy;
    logic signed [20:0] w_cz, w_at;
    assign w_xs = r_cx >>> r_ccnt;
    assign w_ys = r_cy >>> r_ccnt;
    assign w_at = $signed({5'b0, atan_step(r_ccnt)});
    assign w_cx = r_cy[19] ? r_cx - w_ys : r_cx + w_ys;
    assign w_cy = r_cy[19] ? r_cy + w_xs : r_cy - w_xs;
    assign w_cz = r_cy[19] ? r_cz - w_at : r_cz + w_at;

    // Mode decision on the final tilt.
    logic [32:0] w_mag;
    logic        w_past;
    assign w_mag  = r_tilt[31] ? 33'(-34'(r_tilt)) : 33'(r_tilt);
    assign w_past = r_mode ? (w_mag > 33'(r_stop_angle)) : (w_mag < 33'(r_start_angle));

    logic w_quiet;
    assign w_quiet = (r_rate == 13'sd0) || (r_rate == 13'sd1) || (r_rate == -13'sd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_ret           <= S_RATE_Q;
            r_gyro_zero     <= '0;
            r_angle_gain    <= 10'd11;
            r_distance_gain <= 10'd73;
            r_speed_gain    <= 13'd3300;
            r_steer_gain    <= -11'sd50;
            r_speed_limit   <= 10'd300;
            r_start_angle   <= 18'd45000;
            r_stop_angle    <= 18'd70000;
            r_tilt          <= '0;
            r_motor         <= '0;
            r_dist_l        <= '0;
            r_dist_r        <= '0;
            r_prev_l        <= '0;
            r_prev_r        <= '0;
            r_settle        <= '0;
            r_mode          <= 1'b0;
            r_ov            <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GYRO_ZERO:     r_gyro_zero     <= i_cfg_data[15:0];
                    CFG_ANGLE_GAIN:    r_angle_gain    <= i_cfg_data[9:0];
                    CFG_DISTANCE_GAIN: r_distance_gain <= i_cfg_data[9:0];
                    CFG_SPEED_GAIN:    r_speed_gain    <= i_cfg_data[12:0];
                    CFG_STEER_GAIN:    r_steer_gain    <= i_cfg_data[10:0];
                    CFG_SPEED_LIMIT:   r_speed_limit   <= i_cfg_data[9:0];
                    CFG_START_ANGLE:   r_start_angle   <= i_cfg_data;
                    CFG_STOP_ANGLE:    r_stop_angle    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (o_cmd.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_tick.valid) begin
                        r_ax    <= i_tick.accel_x;
                        r_ay    <= i_tick.accel_y;
                        r_enc_l <= i_tick.enc_left;
                        r_enc_r <= i_tick.enc_right;
                        r_left  <= '0;
                        r_right <= '0;
                        r_prod  <= 48'(i_tick.gyro_rate) - 48'(r_gyro_zero);
                        r_ret   <= S_RATE_Q;
                        r_state <= S_DLD;
                    end
                end
                S_DLD: begin
                    r_neg   <= w_dsrc[47];
                    r_quo   <= w_dmag;
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // Even cycles estimate a quotient digit, odd cycles take its remainder.
                    if (!r_dcnt[0]) begin
                        r_qd <= w_digit;
                    end else begin
                        r_rem <= 15'(w_t - w_qd);
                        r_quo <= {r_quo[31:0], r_qd};
                    end
                    r_dcnt <= r_dcnt + 3'd1;
                    if (r_dcnt == 3'(2 * DIV_DIGITS - 1)) begin
                        r_state <= r_ret;
                    end
                end
                S_RATE_Q: begin
                    r_rate   <= w_q[12:0];
                    r_dl     <= w_dl;
                    r_dr     <= w_dr;
                    r_prev_l <= r_enc_l;
                    r_prev_r <= r_enc_r;
                    r_dist_l <= r_dist_l + 32'(w_dl);
                    r_dist_r <= r_dist_r + 32'(w_dr);
                    r_state  <= S_M_TICK;
                end
                S_M_TICK: begin
                    r_prod  <= w_mul;
                    r_state <= S_W_TILT;
                end
                S_W_TILT: begin
                    r_tilt <= r_tilt + r_prod[31:0];
                    if (r_mode) begin
                        r_state <= S_M_DECAY;
                    end else begin
                        r_motor  <= '0;
                        r_dist_l <= '0;
                        r_dist_r <= '0;
                        r_state  <= S_FINISH;
                        if (w_quiet) begin
                            if (r_ax == 16'sd0 && r_ay == 16'sd0) begin
                                r_tilt <= '0;
                            end else begin
                                // Rotate the vector into the right half plane first.
                                if (r_ay < 16'sd0) begin
                                    r_cx <= -20'(r_ay);
                                    r_cy <= -20'(r_ax);
                                    r_cz <= (r_ax >= 16'sd0) ? 21'(HALF_TURN)
                                                             : -21'(HALF_TURN);
                                end else begin
                                    r_cx <= 20'(r_ay);
                                    r_cy <= 20'(r_ax);
                                    r_cz <= '0;
                                end
                                r_ccnt  <= '0;
                                r_state <= S_CORDIC;
                            end
                        end
                    end
                end
                S_M_DECAY: begin
                    r_prod  <= w_mul;
                    r_ret   <= S_DECAY_Q;
                    r_state <= S_DLD;
                end
                S_DECAY_Q: begin
                    r_tilt  <= w_q[31:0];
                    r_state <= S_M_RISE;
                end
                S_M_RISE: begin
                    r_prod  <= w_mul;
                    r_state <= S_A_RISE;
                end
                S_A_RISE: begin
                    r_rising <= r_prod[33:0] + 34'(r_tilt);
                    r_state  <= S_M_ANG;
                end
                S_M_ANG: begin
                    r_prod  <= w_mul;
                    r_state <= S_M_DIST;
                end
                S_M_DIST: begin
                    r_acc   <= r_prod;
                    r_prod  <= w_mul;
                    r_state <= S_M_SPD;
                end
                S_M_SPD: begin
                    r_acc   <= r_acc + r_prod;
                    r_prod  <= w_mul;
                    r_state <= S_A_SPD;
                end
                S_A_SPD: begin
                    r_acc   <= r_acc + r_prod;
                    r_ret   <= S_INC_Q;
                    r_state <= S_DLD;
                end
                S_INC_Q: begin
                    r_motor <= r_motor + w_inc[31:0];
                    r_state <= S_M_STEER;
                end
                S_M_STEER: begin
                    r_prod  <= w_mul;
                    r_ret   <= S_STEER_Q;
                    r_state <= S_DLD;
                end
                S_STEER_Q: begin
                    r_left  <= sat16(w_lsum);
                    r_right <= sat16(w_rsum);
                    r_state <= S_FINISH;
                end
                S_CORDIC: begin
                    r_cx   <= w_cx;
                    r_cy   <= w_cy;
                    r_cz   <= w_cz;
                    r_ccnt <= r_ccnt + 4'd1;
                    if (r_ccnt == 4'(CORDIC_STEPS - 1)) begin
                        r_tilt  <= 32'(w_cz);
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_ov || o_cmd.ready) begin
                        r_ov      <= 1'b1;
                        r_o_left  <= r_left;
                        r_o_right <= r_right;
                        r_o_tilt  <= r_tilt;
                        r_o_bal   <= r_mode;
                        if (w_past) begin
                            if (r_settle >= 3'(SETTLE_TICKS)) begin
                                r_mode    <= !r_mode;
                                r_o_bal   <= !r_mode;
                                r_settle  <= '0;
                            end else begin
                                r_settle <= r_settle + 3'd1;
                            end
                        end else begin
                            r_settle <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_tick.ready        = (r_state == S_IDLE);
    assign o_cmd.valid         = r_ov;
    assign o_cmd.left_drive    = r_o_left;
    assign o_cmd.right_drive   = r_o_right;
    assign o_cmd.balancing_now = r_o_bal;
    assign o_cmd.tilt_out      = r_o_tilt;

endmodule

// ===== rtl/core/brtc_checker.sv =====
// ----------------------------------------------------------------------------
// brtc_checker
// Port-level checks of the tilt controller core, attached by bind.
// ----------------------------------------------------------------------------
module brtc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_left,
    input logic [31:0] i_out_tilt
);

    // Nothing is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("command valid after reset");

    // A stalled command keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_left) && $stable(i_out_tilt))
        else $error("stalled command changed");

    // A tick occupies the sequencer, so no second tick follows directly.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("tick accepted while busy");

    // A new command is only produced while the sequencer was working.
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("command appeared from idle");

endmodule

bind balance_robot_tilt_controller_core brtc_checker u_brtc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_tick.valid),
    .i_in_ready  (i_tick.ready),
    .i_out_valid (o_cmd.valid),
    .i_out_ready (o_cmd.ready),
    .i_out_left  (o_cmd.left_drive),
    .i_out_tilt  (o_cmd.tilt_out)
);
